@@ sv/ftanh_pkg.sv @@
package ftanh_pkg;

    typedef struct packed {
        logic              zero;
        logic [23:0]       m;
        logic signed [11:0] e;
    } t_unp;

    localparam logic [31:0] F_CUTOFF = 32'h41102CB3;
    localparam logic [31:0] F_MAGIC  = 32'h49C00000;
    localparam logic [31:0] F_NMAGIC = 32'hC9C00000;
    localparam logic [31:0] F_NLOG2E = 32'hBFB8AA3B;
    localparam logic [31:0] F_LN2    = 32'h3F317218;
    localparam logic [31:0] F_C4     = 32'hBEAAA7CD;
    localparam logic [31:0] F_C3     = 32'h3F2AB841;
    localparam logic [31:0] F_C2     = 32'hBF800001;
    localparam logic [31:0] F_ONE    = 32'h3F800000;
    localparam logic [31:0] F_NONE   = 32'hBF800000;
    localparam logic [31:0] F_TWO    = 32'h40000000;
    localparam logic [31:0] F_NTWO   = 32'hC0000000;
    localparam logic [31:0] F_ZERO   = 32'h00000000;
    localparam logic [31:0] F_QUIET  = 32'h00400000;
    localparam logic [30:0] F_INF    = 31'h7F800000;

    localparam logic [3:0][31:0] SCALE_TAB = {
        32'h3F7744FD, 32'h3F7504F3, 32'h3F7837F0, 32'h3F800000
    };

    function automatic logic [4:0] f_lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic [6:0] f_lzc78(input logic [77:0] v);
        logic [6:0] n;
        logic       found;
        n = 7'd0;
        found = 1'b0;
        for (int i = 77; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 7'd1;
                end
            end
        end
        return n;
    endfunction

    function automatic t_unp f_unpack(input logic [31:0] f);
        t_unp       u;
        logic [23:0] mr;
        logic [4:0]  la;
        logic [7:0]  eb;
        eb = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
        mr = {|f[30:23], f[22:0]};
        la = f_lzc24(mr);
        u.zero = (mr == 24'd0);
        u.m = mr << la;
        u.e = $signed({4'b0, eb}) - 12'sd150 - $signed({7'b0, la});
        return u;
    endfunction

    function automatic logic signed [11:0] f_kshift(input logic [6:0] lz,
                                                    input logic signed [11:0] w);
        logic signed [11:0] wl;
        logic signed [11:0] lzs;
        wl = w + 12'sd203;
        lzs = $signed({5'b0, lz});
        return (lzs < wl) ? lzs : wl;
    endfunction

    function automatic logic [31:0] f_round(input logic [77:0] s,
                                            input logic signed [11:0] w,
                                            input logic signed [11:0] k,
                                            input logic sgn);
        logic [157:0]       x;
        logic [157:0]       y;
        logic [6:0]         r;
        logic [11:0]        nk;
        logic [23:0]        mant;
        logic               rb;
        logic               st;
        logic               inc;
        logic signed [11:0] eb;
        logic [7:0]         ef;
        logic [30:0]        mag;
        x = {s, 80'b0};
        nk = 12'(-k);
        if (k >= 12'sd0) begin
            y = x << k[6:0];
        end else begin
            r = (k < -12'sd80) ? 7'd80 : nk[6:0];
            y = x >> r;
        end
        mant = y[157:134];
        rb = y[133];
        st = |y[132:0];
        inc = rb & (st | mant[0]);
        eb = w - k + 12'sd204;
        ef = mant[23] ? eb[7:0] : 8'd0;
        mag = {ef, mant[22:0]} + {30'b0, inc};
        return {sgn, mag};
    endfunction

endpackage

@@ sv/ftanh_fma.sv @@
module ftanh_fma import ftanh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [31:0] o_r
);

    t_unp               w_ua;
    t_unp               w_ub;
    logic [23:0]        r1_ma;
    logic [23:0]        r1_mb;
    logic signed [11:0] r1_eab;
    logic               r1_pz;
    logic               r1_sp;
    logic               r1_sc;
    logic [23:0]        r1_mc;
    logic signed [11:0] r1_ec;
    logic [31:0]        r1_c;

    logic signed [11:0] w_shraw;
    logic [6:0]         w_sh;
    logic signed [11:0] w_w2;
    logic [47:0]        r2_p;
    logic [6:0]         r2_sh;
    logic signed [11:0] r2_w;
    logic [23:0]        r2_mc;
    logic               r2_sub;
    logic               r2_sp;
    logic               r2_sc;
    logic               r2_pz;
    logic [31:0]        r2_c;

    logic [156:0]       w_tmp;
    logic [77:0]        w_ca;
    logic [77:0]        w_pw;
    logic [77:0]        w_s3;
    logic               w_sg3;
    logic [77:0]        r3_s;
    logic               r3_sg;
    logic signed [11:0] r3_w;
    logic               r3_pz;
    logic [31:0]        r3_c;

    logic [77:0]        r4_s;
    logic               r4_sg;
    logic signed [11:0] r4_w;
    logic signed [11:0] r4_k;
    logic               r4_pz;
    logic [31:0]        r4_c;
    logic [31:0]        r_r;

    assign w_ua = f_unpack(i_a);
    assign w_ub = f_unpack(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ma  <= w_ua.m;
            r1_mb  <= w_ub.m;
            r1_eab <= w_ua.e + w_ub.e;
            r1_pz  <= w_ua.zero | w_ub.zero;
            r1_sp  <= i_a[31] ^ i_b[31];
            r1_sc  <= i_c[31];
            r1_mc  <= {|i_c[30:23], i_c[22:0]};
            r1_ec  <= (i_c[30:23] == 8'd0) ? -12'sd149
                                             : $signed({4'b0, i_c[30:23]}) - 12'sd150;
            r1_c   <= i_c;
        end
    end

    always_comb begin
        w_shraw = 12'sd50 - r1_ec + r1_eab;
        priority if (r1_mc == 24'd0) begin
            w_sh = 7'd80;
            w_w2 = r1_eab - 12'sd3;
        end else if (w_shraw < 12'sd0) begin
            w_sh = 7'd0;
            w_w2 = r1_ec - 12'sd53;
        end else if (w_shraw > 12'sd80) begin
            w_sh = 7'd80;
            w_w2 = r1_eab - 12'sd3;
        end else begin
            w_sh = w_shraw[6:0];
            w_w2 = r1_eab - 12'sd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p   <= r1_ma * r1_mb;
            r2_sh  <= w_sh;
            r2_w   <= w_w2;
            r2_mc  <= r1_mc;
            r2_sub <= r1_sp ^ r1_sc;
            r2_sp  <= r1_sp;
            r2_sc  <= r1_sc;
            r2_pz  <= r1_pz;
            r2_c   <= r1_c;
        end
    end

    always_comb begin
        w_tmp = {r2_mc, 53'b0, 80'b0} >> r2_sh;
        w_ca  = {1'b0, w_tmp[156:81], w_tmp[80] | (|w_tmp[79:0])};
        w_pw  = {27'b0, r2_p, 3'b0};
        if (!r2_sub) begin
            w_s3  = w_pw + w_ca;
            w_sg3 = r2_sp;
        end else if (w_pw >= w_ca) begin
            w_s3  = w_pw - w_ca;
            w_sg3 = r2_sp;
        end else begin
            w_s3  = w_ca - w_pw;
            w_sg3 = r2_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_s  <= w_s3;
            r3_sg <= w_sg3;
            r3_w  <= r2_w;
            r3_pz <= r2_pz;
            r3_c  <= r2_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_s  <= r3_s;
            r4_sg <= r3_sg;
            r4_w  <= r3_w;
            r4_k  <= f_kshift(f_lzc78(r3_s), r3_w);
            r4_pz <= r3_pz;
            r4_c  <= r3_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= r4_pz ? r4_c : f_round(r4_s, r4_w, r4_k, r4_sg);
        end
    end

    assign o_r = r_r;

endmodule

@@ sv/ftanh_div.sv @@
module ftanh_div import ftanh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_q
);

    t_unp               w_ua;
    t_unp               w_ub;
    logic [24:0]        r_rem [0:27];
    logic [23:0]        r_den [0:27];
    logic [26:0]        r_quo [0:27];
    logic signed [11:0] r_w   [0:27];
    logic [77:0]        w_s;
    logic [77:0]        r_s;
    logic signed [11:0] r_wf;
    logic signed [11:0] r_k;
    logic [31:0]        r_q;

    assign w_ua = f_unpack({1'b0, i_a[30:0]});
    assign w_ub = f_unpack({1'b0, i_b[30:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, w_ua.m};
            r_den[0] <= w_ub.m;
            r_quo[0] <= 27'd0;
            r_w[0]   <= w_ua.e - w_ub.e - 12'sd77;
            for (int i = 1; i < 28; i++) begin
                if (r_rem[i-1] >= {1'b0, r_den[i-1]}) begin
                    r_rem[i] <= {r_rem[i-1][23:0] - r_den[i-1], 1'b0};
                    r_quo[i] <= {r_quo[i-1][25:0], 1'b1};
                end else begin
                    r_rem[i] <= {r_rem[i-1][23:0], 1'b0};
                    r_quo[i] <= {r_quo[i-1][25:0], 1'b0};
                end
                r_den[i] <= r_den[i-1];
                r_w[i]   <= r_w[i-1];
            end
        end
    end

    assign w_s = {r_quo[27], 50'b0, |r_rem[27]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s  <= w_s;
            r_wf <= r_w[27];
            r_k  <= f_kshift(f_lzc78(w_s), r_w[27]);
            r_q  <= f_round(r_s, r_wf, r_k, 1'b0);
        end
    end

    assign o_q = r_q;

endmodule

@@ sv/fp32_tanh_expm1_lut4_poly4_top.sv @@
// Single-precision tanh, one binary32 value per request.
// Input channel: i_valid, i_x_bits, i_last_in; the block drives o_stall.
// Output channel: o_valid, o_y_bits, o_last_out; the receiver drives i_stall.
// A request is taken on a rising edge with valid high and stall low.
// Throughput: one request per cycle while o_stall is low; the work is a
// chain of nine fused multiply-add units of five stages each plus a 30-stage
// radix-2 divider, with two more such units feeding the chain.
// NaN inputs return the input with the quiet bit set; the sign of x is
// copied to the result otherwise. o_last_out follows its request unchanged.
// Reset (synchronous, active low) empties the pipeline and drops o_valid.
// While a result is held on the output and i_stall is high, the whole
// pipeline freezes and o_stall is raised; nothing is lost or repeated.
module fp32_tanh_expm1_lut4_poly4_top import ftanh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_x_bits,
    input  logic        i_last_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_y_bits,
    output logic        o_last_out
);

    logic        w_en;
    logic [75:0] r_v;
    logic [31:0] r_x   [0:75];
    logic        r_l   [0:75];
    logic [31:0] r_z   [0:9];
    logic [31:0] r_s   [0:9];
    logic [31:0] r_t   [0:9];
    logic [31:0] r_ts  [0:9];
    logic [31:0] r_sm1 [0:14];
    logic [31:0] r_em1 [0:4];
    logic        r_out_valid;
    logic [31:0] r_y_bits;
    logic        r_last_out;

    logic [31:0] w_abs;
    logic [31:0] w_z;
    logic [31:0] w_n;
    logic [31:0] w_s;
    logic [31:0] w_nm;
    logic [31:0] w_t;
    logic [31:0] w_p4;
    logic [31:0] w_p5;
    logic [31:0] w_p6;
    logic [31:0] w_p7;
    logic [31:0] w_ts;
    logic [31:0] w_sm1;
    logic [31:0] w_em1;
    logic [31:0] w_ep1;
    logic [31:0] w_q;
    logic        w_nan;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    assign w_abs = {1'b0, r_x[0][30:0]};
    assign w_z   = (w_abs > F_CUTOFF) ? F_CUTOFF : w_abs;
    assign w_s   = SCALE_TAB[w_n[1:0]] + {w_n[10:0], 21'b0};

    ftanh_fma u_f1 (.i_clk(i_clk), .i_en(w_en), .i_a(w_z), .i_b(F_NLOG2E),
                    .i_c(F_MAGIC), .o_r(w_n));
    ftanh_fma u_f2 (.i_clk(i_clk), .i_en(w_en), .i_a(w_n), .i_b(F_ONE),
                    .i_c(F_NMAGIC), .o_r(w_nm));
    ftanh_fma u_f3 (.i_clk(i_clk), .i_en(w_en), .i_a(w_nm), .i_b(F_LN2),
                    .i_c(r_z[9]), .o_r(w_t));
    ftanh_fma u_f4 (.i_clk(i_clk), .i_en(w_en), .i_a(F_C4), .i_b(w_t),
                    .i_c(F_C3), .o_r(w_p4));
    ftanh_fma u_fts (.i_clk(i_clk), .i_en(w_en), .i_a(w_t), .i_b(r_s[9]),
                     .i_c(F_ZERO), .o_r(w_ts));
    ftanh_fma u_fsm1 (.i_clk(i_clk), .i_en(w_en), .i_a(r_s[9]), .i_b(F_ONE),
                      .i_c(F_NONE), .o_r(w_sm1));
    ftanh_fma u_f5 (.i_clk(i_clk), .i_en(w_en), .i_a(w_p4), .i_b(r_t[4]),
                    .i_c(F_C2), .o_r(w_p5));
    ftanh_fma u_f6 (.i_clk(i_clk), .i_en(w_en), .i_a(w_p5), .i_b(r_t[9]),
                    .i_c(F_ZERO), .o_r(w_p6));
    ftanh_fma u_f7 (.i_clk(i_clk), .i_en(w_en), .i_a(w_p6), .i_b(r_ts[9]),
                    .i_c(r_ts[9]), .o_r(w_p7));
    ftanh_fma u_f8 (.i_clk(i_clk), .i_en(w_en), .i_a(w_p7), .i_b(F_NTWO),
                    .i_c(r_sm1[14]), .o_r(w_em1));
    ftanh_fma u_f9 (.i_clk(i_clk), .i_en(w_en), .i_a(w_em1), .i_b(F_ONE),
                    .i_c(F_TWO), .o_r(w_ep1));
    ftanh_div u_div (.i_clk(i_clk), .i_en(w_en), .i_a(r_em1[4]), .i_b(w_ep1),
                     .o_q(w_q));

    assign w_nan = r_x[75][30:0] > F_INF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v         <= {r_v[74:0], i_valid};
            r_out_valid <= r_v[75];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0] <= i_x_bits;
            r_l[0] <= i_last_in;
            for (int i = 1; i < 76; i++) begin
                r_x[i] <= r_x[i-1];
                r_l[i] <= r_l[i-1];
            end
            r_z[0]   <= w_z;
            r_s[0]   <= w_s;
            r_t[0]   <= w_t;
            r_ts[0]  <= w_ts;
            r_sm1[0] <= w_sm1;
            r_em1[0] <= w_em1;
            for (int i = 1; i < 10; i++) begin
                r_z[i]  <= r_z[i-1];
                r_s[i]  <= r_s[i-1];
                r_t[i]  <= r_t[i-1];
                r_ts[i] <= r_ts[i-1];
            end
            for (int i = 1; i < 15; i++) begin
                r_sm1[i] <= r_sm1[i-1];
            end
            for (int i = 1; i < 5; i++) begin
                r_em1[i] <= r_em1[i-1];
            end
            r_y_bits   <= w_nan ? (r_x[75] | F_QUIET) : {r_x[75][31], w_q[30:0]};
            r_last_out <= r_l[75];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_y_bits   = r_y_bits;
    assign o_last_out = r_last_out;

endmodule

@@ dv/ftanh_checker.sv @@
module ftanh_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [31:0] i_x_bits,
    input  logic        i_last_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_y_bits,
    input  logic        i_last_out,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] y_bits;
        logic        last;
    } tanh_result_t;

    tanh_result_t tanh_results_q[$];

    function automatic real sp_to_real(input logic [31:0] f);
        logic [63:0] d;
        if (f[30:23] == 8'hFF) begin
            d = {f[31], 11'h7FF, 52'd0};
        end else if (f[30:23] == 8'd0) begin
            d = {1'b0, 11'(1023 - 149), 52'd0};
            return (f[31] ? -1.0 : 1.0) * real'(f[22:0]) * $bitstoreal(d);
        end else begin
            d = {f[31], 11'(f[30:23] - 127 + 1023), f[22:0], 29'd0};
        end
        return $bitstoreal(d);
    endfunction

    function automatic logic [31:0] real_to_sp(input real v);
        logic [63:0] b;
        logic [63:0] m;
        logic [63:0] n;
        logic [63:0] rem;
        logic [63:0] half;
        int          eu;
        int          q;
        int          k;
        b = $realtobits(v);
        if (b[62:52] == 11'h7FF) return {b[63], 31'h7F800000};
        if (b[62:0] == 63'd0) return {b[63], 31'd0};
        eu = int'(b[62:52]) - 1023;
        q = eu - 23;
        if (q < -149) q = -149;
        k = q - eu + 52;
        m = {12'd1, b[51:0]};
        if (k >= 54) return {b[63], 31'd0};
        n = m >> k;
        rem = m & ((64'd1 << k) - 64'd1);
        half = 64'd1 << (k - 1);
        if (rem > half || (rem == half && n[0])) n = n + 64'd1;
        if (n == 64'd0) return {b[63], 31'd0};
        if (n == 64'h1000000) begin
            n = n >> 1;
            q = q + 1;
        end
        if (q == -149 && n < 64'h800000) return {b[63], 8'd0, n[22:0]};
        if (q + 150 >= 255) return {b[63], 31'h7F800000};
        return {b[63], 8'(q + 150), n[22:0]};
    endfunction

    function automatic bit on_sp_midpoint(input real s);
        logic [63:0] b;
        logic [63:0] m;
        int          eu;
        int          q;
        int          k;
        b = $realtobits(s);
        if (b[62:52] == 11'd0 || b[62:52] == 11'h7FF) return 1'b0;
        eu = int'(b[62:52]) - 1023;
        q = eu - 23;
        if (q < -149) q = -149;
        k = q - eu + 52;
        if (k < 1 || k > 53) return 1'b0;
        m = {12'd1, b[51:0]};
        return (m & ((64'd1 << k) - 64'd1)) == (64'd1 << (k - 1));
    endfunction

    function automatic logic [31:0] sp_fma(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
        real         p;
        real         cc;
        real         s;
        real         bb;
        real         e;
        logic [63:0] sb;
        p = sp_to_real(a) * sp_to_real(b);
        cc = sp_to_real(c);
        s = p + cc;
        bb = s - p;
        e = (p - (s - bb)) + (cc - bb);
        if (e != 0.0 && on_sp_midpoint(s)) begin
            sb = $realtobits(s);
            sb = (sb[63] == (e < 0.0)) ? sb + 64'd1 : sb - 64'd1;
            s = $bitstoreal(sb);
        end
        return real_to_sp(s);
    endfunction

    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        return real_to_sp(sp_to_real(a) * sp_to_real(b));
    endfunction

    function automatic logic [31:0] sp_sub(input logic [31:0] a, input logic [31:0] b);
        return real_to_sp(sp_to_real(a) - sp_to_real(b));
    endfunction

    function automatic logic [31:0] tanh_of(input logic [31:0] x);
        logic [31:0] z;
        logic [31:0] n;
        logic [31:0] s;
        logic [31:0] t;
        logic [31:0] p;
        logic [31:0] ts;
        logic [31:0] sm1;
        logic [31:0] em1;
        logic [31:0] ep1;
        logic [31:0] ay;
        logic [31:0] lut;
        if (x[30:0] > 31'h7F800000) return x | 32'h00400000;
        z = {1'b0, x[30:0]};
        if (sp_to_real(32'h41102CB3) < sp_to_real(z)) z = 32'h41102CB3;
        n = sp_fma(z, 32'hBFB8AA3B, 32'h49C00000);
        case (n[1:0])
            2'd0: lut = 32'h3F800000;
            2'd1: lut = 32'h3F7837F0;
            2'd2: lut = 32'h3F7504F3;
            default: lut = 32'h3F7744FD;
        endcase
        s = lut + (n << 21);
        n = sp_sub(n, 32'h49C00000);
        t = sp_fma(n, 32'h3F317218, z);
        p = sp_fma(32'hBEAAA7CD, t, 32'h3F2AB841);
        p = sp_fma(p, t, 32'hBF800001);
        p = sp_mul(p, t);
        ts = sp_mul(t, s);
        sm1 = sp_sub(s, 32'h3F800000);
        p = sp_fma(p, ts, ts);
        em1 = sp_fma(p, 32'hC0000000, sm1);
        ep1 = sp_sub(em1, 32'hC0000000);
        if (sp_to_real(ep1) == 0.0) ay = 32'd0;
        else ay = real_to_sp(sp_to_real(em1) / sp_to_real(ep1));
        return {x[31], ay[30:0]};
    endfunction

    initial o_fail_count = 0;
    assign o_pending = tanh_results_q.size();

    always @(posedge i_clk) begin
        tanh_result_t exp_r;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (tanh_results_q.size() == 0) begin
                    $error("unexpected result y_bits=%h", i_y_bits);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = tanh_results_q.pop_front();
                    if (exp_r.y_bits !== i_y_bits || exp_r.last !== i_last_out) begin
                        if (exp_r.y_bits !== i_y_bits)
                            $error("y_bits expected %h actual %h", exp_r.y_bits, i_y_bits);
                        if (exp_r.last !== i_last_out)
                            $error("last_out expected %b actual %b", exp_r.last, i_last_out);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && !i_stall_in) begin
                exp_r.y_bits = tanh_of(i_x_bits);
                exp_r.last = i_last_in;
                tanh_results_q.push_back(exp_r);
            end
        end
    end
endmodule

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1130;
    localparam int CYCLE_LIMIT = 300000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_x_bits;
    logic        i_last_in;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_y_bits;
    logic        o_last_out;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          quiet;

    fp32_tanh_expm1_lut4_poly4_top dut (.*);

    ftanh_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_x_bits(i_x_bits), .i_last_in(i_last_in),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_y_bits(o_y_bits), .i_last_out(o_last_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_x_bits = 32'd0;
        i_last_in = 1'b0;
        i_stall = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end
    initial cycles = 0;

    task automatic send_request(input logic [31:0] x, input logic last);
        i_valid <= 1'b1;
        i_x_bits <= x;
        i_last_in <= last;
        do @(posedge i_clk); while (o_stall);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] random_x();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0, 1: ;
            2: v[30:23] = 8'($urandom_range(0, 8));
            3: v[30:23] = 8'hFF;
            default: v[30:23] = 8'($urandom_range(8'h60, 8'h84));
        endcase
        return v;
    endfunction

    initial begin
        logic [31:0] directed[$];
        directed = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                     32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF, 32'h00000001,
                     32'h80000001, 32'h007FFFFF, 32'h3F800000, 32'hBF800000,
                     32'h41102CB3, 32'h41102CB4, 32'hC1102CB2, 32'h7F7FFFFF,
                     32'h3A000000, 32'h33800000, 32'h3F000000, 32'h40000000,
                     32'hC0A00000, 32'h00800000, 32'hBE800000, 32'h7FBFFFFF};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) send_request(directed[i], i == directed.size() - 1);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 150) quiet = 1'b1;
            send_request(random_x(), $urandom_range(0, 15) == 0);
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        @(posedge i_rst_n);
        repeat (200) @(posedge i_clk);
        i_stall <= 1'b1;
        repeat (300) @(posedge i_clk);
        i_stall <= 1'b0;
        while (!quiet) begin
            @(posedge i_clk);
            if ($urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(0, 40)) @(posedge i_clk);
            end
        end
    end
endmodule

@@ fp32_tanh_expm1_lut4_poly4_top.f @@
sv/ftanh_pkg.sv
sv/ftanh_fma.sv
sv/ftanh_div.sv
sv/fp32_tanh_expm1_lut4_poly4_top.sv
dv/ftanh_checker.sv
dv/tb.sv
